[hdl/cmscan_pkg.sv]
// ----------------------------------------------------------------------------
// cmscan_pkg
// Shared constants and the pin pair table of the charlieplexed matrix scanner.
// ----------------------------------------------------------------------------
package cmscan_pkg;

  localparam int PinCount    = 11;
  localparam int PairGroups  = 10;
  localparam int LedCountDef = 104;
  localparam int LedCountMax = PairGroups * (PairGroups + 1);
  localparam int PinIdxW     = 4;
  localparam int LedIdxW     = 7;

  typedef enum logic {
    OP_SCAN  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  // entry: [7:4] high pin, [3:0] low pin
  typedef logic [LedCountMax-1:0][2*PinIdxW-1:0] pair_tab_t;

  function automatic pair_tab_t build_pairs();
    pair_tab_t t;
    int n;
    t = '0;
    n = 0;
    for (int k = 1; k <= PairGroups; k++) begin
      for (int j = 0; j < k; j++) begin
        t[n]     = {PinIdxW'(j), PinIdxW'(k)};
        t[n + 1] = {PinIdxW'(k), PinIdxW'(j)};
        n += 2;
      end
    end
    return t;
  endfunction

  localparam pair_tab_t PairTable = build_pairs();

endpackage

[hdl/charlieplex_matrix_scanner_unit.sv]
// ----------------------------------------------------------------------------
// charlieplex_matrix_scanner_unit
// Frame store and scan sequencer for a charlieplexed LED matrix on 11 pins.
// ----------------------------------------------------------------------------
// channel  | direction | tuser  | tdata (lowest bit up)
// s_axis   | in        | opcode | byte_index[3:0], byte_value[11:4], zero
// m_axis   | out       | -      | pin_enable[10:0], pin_high[21:11],
//          |           |        | led_index[28:22], lit[29], zero
//
// One item per cycle while m_axis is not stalled; a scan tick's result appears in the
// cycle after acceptance, held in the single result register after the table lookup.
// Writes give no result. Reset clears the frame store and the scan position.
// While the result register is full and m_axis_tready_i is low, input stalls.
// ----------------------------------------------------------------------------
module charlieplex_matrix_scanner_unit
  import cmscan_pkg::*;
#(
  parameter int LED_COUNT = LedCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // byte_index, byte_value, zero
  input  logic        s_axis_tuser_i,  // opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // pin_enable, pin_high, led_index, lit, zero
);

  localparam int StoreBytes = (LED_COUNT + 7) / 8;
  localparam int ByteIdxW   = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;

  logic [7:0]          frame_q [StoreBytes];
  logic [LedIdxW-1:0]  scan_q, scan_d;
  logic                valid_q;
  logic [PinCount-1:0] enable_q, enable_d;
  logic [PinCount-1:0] high_q, high_d;
  logic [LedIdxW-1:0]  index_q;
  logic                lit_q, lit_d;

  logic                accept;
  opcode_e             opcode;
  logic [3:0]          byte_index;
  logic [7:0]          byte_value;
  logic [ByteIdxW-1:0] rd_sel;
  logic [PinIdxW-1:0]  hi_pin, lo_pin;

  assign opcode     = opcode_e'(s_axis_tuser_i);
  assign byte_index = s_axis_tdata_i[3:0];
  assign byte_value = s_axis_tdata_i[11:4];

  assign s_axis_tready_o = !valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign rd_sel = ByteIdxW'(scan_q >> 3);
  assign {hi_pin, lo_pin} = PairTable[scan_q];

  always_comb begin
    lit_d    = frame_q[rd_sel][scan_q[2:0]];
    enable_d = '0;
    high_d   = '0;
    if (lit_d) begin
      enable_d = (PinCount'(1) << hi_pin) | (PinCount'(1) << lo_pin);
      high_d   = PinCount'(1) << hi_pin;
    end
    if (32'(scan_q) + 32'd1 >= 32'(LED_COUNT)) begin
      scan_d = '0;
    end else begin
      scan_d = scan_q + LedIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < StoreBytes; n++) begin
        frame_q[n] <= '0;
      end
      scan_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept && opcode == OP_SCAN) begin
        valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        valid_q <= 1'b0;
      end
      if (accept) begin
        case (opcode)
          OP_WRITE: begin
            if (32'(byte_index) < 32'(StoreBytes)) begin
              frame_q[ByteIdxW'(byte_index)] <= byte_value;
            end
          end
          OP_SCAN: begin
            scan_q <= scan_d;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && opcode == OP_SCAN) begin
      enable_q <= enable_d;
      high_q   <= high_d;
      index_q  <= scan_q;
      lit_q    <= lit_d;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {2'b00, lit_q, index_q, high_q, enable_q};

  a_dark_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !lit_q) |-> (enable_q == '0 && high_q == '0))
    else $error("dark LED drives pins");

  a_lit_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && lit_q) |-> ($countones(enable_q) == 2 && $onehot(high_q)
                            && (high_q & ~enable_q) == '0))
    else $error("lit LED pin masks malformed");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(scan_q) < 32'(LED_COUNT))
    else $error("scan position out of range");

  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode == OP_SCAN) |=> valid_q)
    else $error("scan tick lost its result");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the charlieplexed matrix scanner. Frame writes and
// scan ticks are driven on the input stream. Each accepted tick is predicted
// from a local copy of the frame store and scan position. Every result on the
// output stream is compared field by field with the oldest pending drive.
// Both sides idle at random, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cmscan_pkg::*;

  localparam int StoreBytes = (LedCountDef + 7) / 8;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 80;

  typedef struct packed {
    logic [PinCount-1:0] pin_enable;
    logic [PinCount-1:0] pin_high;
    logic [LedIdxW-1:0]  led_index;
    logic                lit;
  } led_drive_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = OP_SCAN;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  logic [7:0]  frame_copy [StoreBytes];
  int unsigned scan_led;
  led_drive_t  drive_q [$];

  bit          src_idle = 1'b1;
  bit          sink_idle = 1'b1;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  int unsigned errors = 0;
  int unsigned n_scans = 0;
  int unsigned n_lit = 0;
  int unsigned n_wraps = 0;
  int unsigned n_writes = 0;
  int unsigned n_ignored = 0;
  int unsigned input_stalls = 0;

  charlieplex_matrix_scanner_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Timeout after %0d cycles with %0d drives pending", CycleLimit, drive_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  // group k holds 2k LEDs: (j,k) then (k,j) for each j < k
  function automatic void pin_pair(input int unsigned led, output int unsigned hi,
                                   output int unsigned lo);
    int unsigned first;
    int unsigned k;
    int unsigned off;
    first = 0;
    k = 1;
    while (led >= first + 2 * k) begin
      first += 2 * k;
      k++;
    end
    off = led - first;
    hi  = off[0] ? k : off >> 1;
    lo  = off[0] ? off >> 1 : k;
  endfunction

  function automatic void apply_item(input opcode_e op, input logic [3:0] idx,
                                     input logic [7:0] val);
    led_drive_t  d;
    int unsigned hi;
    int unsigned lo;
    if (op == OP_WRITE) begin
      n_writes++;
      if (idx < StoreBytes) frame_copy[idx] = val;
      else n_ignored++;
      return;
    end
    d = '0;
    d.led_index = LedIdxW'(scan_led);
    d.lit = frame_copy[scan_led >> 3][scan_led & 7];
    if (d.lit) begin
      pin_pair(scan_led, hi, lo);
      d.pin_enable = (PinCount'(1) << hi) | (PinCount'(1) << lo);
      d.pin_high   = PinCount'(1) << hi;
    end
    drive_q.push_back(d);
    n_scans++;
    if (d.lit) n_lit++;
    if (scan_led == LedCountDef - 1) n_wraps++;
    scan_led = (scan_led + 1 >= LedCountDef) ? 0 : scan_led + 1;
  endfunction

  always @(posedge clk_i) begin
    led_drive_t got;
    led_drive_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = '{pin_enable: m_tdata[10:0], pin_high: m_tdata[21:11],
                led_index: m_tdata[28:22], lit: m_tdata[29]};
        if (drive_q.size() == 0) begin
          $error("unexpected result: led_index %0d", got.led_index);
          errors++;
        end else begin
          want = drive_q.pop_front();
          if (got.pin_enable !== want.pin_enable) begin
            $error("pin_enable: expected %h, got %h", want.pin_enable, got.pin_enable);
            errors++;
          end
          if (got.pin_high !== want.pin_high) begin
            $error("pin_high: expected %h, got %h", want.pin_high, got.pin_high);
            errors++;
          end
          if (got.led_index !== want.led_index) begin
            $error("led_index: expected %0d, got %0d", want.led_index, got.led_index);
            errors++;
          end
          if (got.lit !== want.lit) begin
            $error("lit: expected %b, got %b", want.lit, got.lit);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) apply_item(opcode_e'(s_tuser), s_tdata[3:0], s_tdata[11:4]);
      if (s_tvalid && !s_tready) input_stalls++;
    end
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (hold_req != 0) begin
      hold_left = hold_req - 1;
      hold_req  = 0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(sink_idle && $urandom_range(0, 99) < 8);
    end
  end

  task automatic send_item(input opcode_e op, input logic [3:0] idx, input logic [7:0] val);
    while (src_idle && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, val, idx};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  task automatic test_dark_after_reset();
    send_item(OP_SCAN, 4'hF, 8'hFF);
    send_item(OP_SCAN, 4'h0, 8'h00);
    send_item(OP_SCAN, 4'hA, 8'h5A);
  endtask

  task automatic test_store_writes();
    send_item(OP_WRITE, 4'd0, 8'hFF);
    send_item(OP_WRITE, 4'd12, 8'hFF);
    send_item(OP_WRITE, 4'd13, 8'hFF);
    send_item(OP_WRITE, 4'd14, 8'hAA);
    send_item(OP_WRITE, 4'd15, 8'h55);
    send_item(OP_WRITE, 4'd1, 8'hA5);
    send_item(OP_WRITE, 4'd8, 8'h00);
    for (int i = 0; i < 14; i++) send_item(OP_SCAN, 4'($urandom), 8'($urandom));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned done;
    logic [3:0]  idx;
    logic [7:0]  val;
    done = 0;
    while (done < count) begin
      src_idle  = (done >= 150);
      sink_idle = (done >= 150);
      if ($urandom_range(0, 99) < 30) begin
        idx = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(13, 15))
                                          : 4'($urandom_range(0, StoreBytes - 1));
        case ($urandom_range(0, 3))
          0:       val = 8'h00;
          1:       val = 8'hFF;
          default: val = 8'($urandom);
        endcase
        send_item(OP_WRITE, idx, val);
        if (idx < StoreBytes) done++;
      end else begin
        send_item(OP_SCAN, 4'($urandom), 8'($urandom));
        done++;
      end
    end
  endtask

  task automatic test_output_backpressure();
    for (int n = 0; n < StoreBytes; n++) send_item(OP_WRITE, 4'(n), 8'hFF);
    hold_req = HoldCycles;
    for (int i = 0; i < 50; i++) send_item(OP_SCAN, 4'($urandom), 8'($urandom));
  endtask

  initial begin
    for (int n = 0; n < StoreBytes; n++) frame_copy[n] = 8'h00;
    scan_led = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_dark_after_reset();
    test_store_writes();
    test_random_traffic(560);
    test_output_backpressure();

    s_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d scan ticks (%0d lit, %0d passes through the last LED)",
             n_scans, n_lit, n_wraps);
    $display("and %0d frame writes (%0d beyond the store); input held off %0d cycles",
             n_writes, n_ignored, input_stalls);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[charlieplex_matrix_scanner_unit.f]
hdl/cmscan_pkg.sv
hdl/charlieplex_matrix_scanner_unit.sv
tb/tb.sv
